/* design/slfr_pkg.sv */
// Shared constants for the sync/length/sum frame receiver.
`default_nettype none
package slfr_pkg;

	localparam int unsigned MAX_PAYLOAD = 20;
	localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned TICK_W      = 16;

	localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h41;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd300;
	localparam logic [TICK_W-1:0] TICK_MAX    = '1;

endpackage
`default_nettype wire

/* design/slfr_if.sv */
// Channel interfaces of the frame receiver: input items, results, configuration.
`default_nettype none
interface slfr_in_if;
	import slfr_pkg::*;
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface slfr_out_if;
	import slfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] command;
	logic [LEN_W-1:0]  payload_length;
	logic              has_data;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0]  byte_index;
	logic              last;

	modport source (output valid, output command, output payload_length, output has_data,
		output data_byte, output byte_index, output last, input ready);
	modport sink   (input valid, input command, input payload_length, input has_data,
		input data_byte, input byte_index, input last, output ready);
endinterface

interface slfr_cfg_if;
	import slfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/sync_len_sum_frame_receiver_unit.sv */
// Top level: serial frame receiver with double-banked payload memory and result drain.
// Input: one item (byte or tick) per cycle; while the receiver waits for a checksum byte,
// every input item stalls until the previous frame's results have all been issued from
// the other memory bank.
// Results: first via drain_busy_q and the output stage after the matching checksum byte,
// then one per cycle while res.ready is high (single registered payload-memory read port).
// Reset (arst_n low, asynchronous): hunting for sync, counters and sums zero,
// timeout 300 ticks, no results pending. Payload memory is not cleared.
`default_nettype none
module sync_len_sum_frame_receiver_unit (
	input  wire          clk,
	input  wire          arst_n,
	slfr_in_if.sink      rx,
	slfr_out_if.source   res,
	slfr_cfg_if.sink     cfg
);
	import slfr_pkg::*;

	localparam int unsigned DEPTH = 2 * MAX_PAYLOAD;
	localparam int unsigned AW    = $clog2(DEPTH);

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_CMD  = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_SUM  = 5'b10000
	} phase_t;

	// receive state
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [TICK_W-1:0] idle_q, idle_d;
	logic [TICK_W-1:0] timeout_q;
	logic              wr_bank_q;

	// drain state
	logic              drain_busy_q;
	logic [LEN_W-1:0]  drain_idx_q;
	logic [LEN_W-1:0]  drain_len_q;
	logic [BYTE_W-1:0] drain_cmd_q;
	logic              drain_bank_q;

	// output stage
	logic              valid_s1;
	logic              has_s1;
	logic              last_s1;
	logic [LEN_W-1:0]  idx_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [BYTE_W-1:0] cmd_s1;
	logic [BYTE_W-1:0] rdata_q;

	logic [BYTE_W-1:0] mem [DEPTH];

	logic              acc;
	logic              launch;
	logic              mem_we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic              issue;
	logic              issue_last;
	phase_t            eff_phase;
	logic [BYTE_W-1:0] c;
	logic [LEN_W:0]    count_inc;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !((phase_q == PH_SUM) && drain_busy_q);
	assign acc       = rx.valid && rx.ready;
	assign c         = rx.rx_byte;
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign eff_phase = (idle_q > timeout_q) ? PH_HUNT : phase_q;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		sum_d   = sum_q;
		idle_d  = idle_q;
		launch  = 1'b0;
		mem_we  = 1'b0;
		if (acc) begin
			if (rx.func) begin
				if (idle_q != TICK_MAX) begin
					idle_d = idle_q + 1'b1;
				end
			end else begin
				idle_d = '0;
				phase_d = eff_phase;
				case (eff_phase)
					PH_HUNT: begin
						if (c == SYNC_BYTE) begin
							phase_d = PH_CMD;
							count_d = '0;
						end
					end
					PH_CMD: begin
						cmd_d   = c;
						sum_d   = c;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						sum_d = sum_q + c;
						len_d = c[LEN_W-1:0];
						if (c > BYTE_W'(MAX_PAYLOAD)) begin
							phase_d = PH_HUNT;
						end else if (c == '0) begin
							phase_d = PH_SUM;
						end else begin
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						sum_d = sum_q + c;
						if (count_q < LEN_W'(MAX_PAYLOAD)) begin
							mem_we  = 1'b1;
							count_d = count_inc[LEN_W-1:0];
							if (count_inc >= {1'b0, len_q}) begin
								phase_d = PH_SUM;
							end
						end else if (count_q >= len_q) begin
							phase_d = PH_SUM;
						end
					end
					PH_SUM: begin
						if (c == sum_q) begin
							launch  = 1'b1;
							phase_d = PH_HUNT;
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	assign waddr = AW'(count_q) + (wr_bank_q ? AW'(MAX_PAYLOAD) : AW'(0));
	assign raddr = AW'(drain_idx_q) + (drain_bank_q ? AW'(MAX_PAYLOAD) : AW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			count_q   <= '0;
			len_q     <= '0;
			cmd_q     <= '0;
			sum_q     <= '0;
			idle_q    <= '0;
			timeout_q <= TIMEOUT_RST;
			wr_bank_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			sum_q   <= sum_d;
			idle_q  <= idle_d;
			if (cfg.valid) begin
				timeout_q <= cfg.data;
			end
			// next frame fills the other bank
			if (launch) begin
				wr_bank_q <= !wr_bank_q;
			end
		end
	end

	// payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= c;
		end
		if (issue) begin
			rdata_q <= mem[raddr];
		end
	end

	assign issue      = drain_busy_q && (!valid_s1 || res.ready);
	assign issue_last = (drain_len_q == '0) ||
		({1'b0, drain_idx_q} + 1'b1 == {1'b0, drain_len_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_busy_q <= 1'b0;
			drain_idx_q  <= '0;
			drain_len_q  <= '0;
			drain_cmd_q  <= '0;
			drain_bank_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (launch) begin
				drain_busy_q <= 1'b1;
				drain_idx_q  <= '0;
				drain_len_q  <= len_q;
				drain_cmd_q  <= cmd_q;
				drain_bank_q <= wr_bank_q;
			end else if (issue) begin
				drain_idx_q <= drain_idx_q + 1'b1;
				if (issue_last) begin
					drain_busy_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (res.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			has_s1  <= (drain_len_q != '0);
			last_s1 <= issue_last;
			idx_s1  <= drain_idx_q;
			len_s1  <= drain_len_q;
			cmd_s1  <= drain_cmd_q;
		end
	end

	assign res.valid          = valid_s1;
	assign res.command        = cmd_s1;
	assign res.payload_length = len_s1;
	assign res.has_data       = has_s1;
	assign res.data_byte      = has_s1 ? rdata_q : '0;
	assign res.byte_index     = idx_s1;
	assign res.last           = last_s1;

	a_no_launch_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> !drain_busy_q)
		else $error("frame launched while previous frame still draining");

	a_bank_separation: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && drain_busy_q) |-> (wr_bank_q != drain_bank_q))
		else $error("payload write into the bank being drained");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && has_s1) |-> (idx_s1 < len_s1))
		else $error("byte_index beyond payload_length");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !has_s1) |-> (last_s1 && idx_s1 == '0))
		else $error("empty frame result not marked last");

endmodule
`default_nettype wire
